// ----- sv/pcf_pkg.sv -----
`timescale 1ns / 1ps
package pcf_pkg;

   localparam int unsigned CordicStepsDefault = 20;
   localparam int unsigned CordicStepsMax     = 32;
   localparam int unsigned VecShift           = 14;
   localparam int unsigned CordicWidth        = 40;
   localparam int unsigned AngleWidth         = 32;

   localparam logic signed [AngleWidth-1:0] Ang180 = 32'sd11796480;

   localparam logic [15:0] GyroOffsetReset = 16'd16;
   localparam logic [15:0] GyroGainReset   = 16'd4;
   localparam logic [16:0] BlendAlphaReset = 17'd66;
   localparam logic [16:0] AlphaOne        = 17'd65536;

   localparam logic [1:0] RegGyroOffset = 2'd0;
   localparam logic [1:0] RegGyroGain   = 2'd1;
   localparam logic [1:0] RegBlendAlpha = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ROTATE,
      ST_MUL_GAIN,
      ST_MUL_ACC,
      ST_MUL_GYR,
      ST_SUM,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic load;
      logic rotate;
   } cordic_ctl_type;

   function automatic logic signed [AngleWidth-1:0] atan_lookup(input logic [4:0] idx);
      logic signed [AngleWidth-1:0] r;
      r = '0;
      case (idx)
         5'd0:  r = 32'sd2949120;
         5'd1:  r = 32'sd1740967;
         5'd2:  r = 32'sd919879;
         5'd3:  r = 32'sd466945;
         5'd4:  r = 32'sd234379;
         5'd5:  r = 32'sd117304;
         5'd6:  r = 32'sd58666;
         5'd7:  r = 32'sd29335;
         5'd8:  r = 32'sd14668;
         5'd9:  r = 32'sd7334;
         5'd10: r = 32'sd3667;
         5'd11: r = 32'sd1833;
         5'd12: r = 32'sd917;
         5'd13: r = 32'sd458;
         5'd14: r = 32'sd229;
         5'd15: r = 32'sd115;
         5'd16: r = 32'sd57;
         5'd17: r = 32'sd29;
         5'd18: r = 32'sd14;
         5'd19: r = 32'sd7;
         5'd20: r = 32'sd4;
         5'd21: r = 32'sd2;
         5'd22: r = 32'sd1;
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage

// ----- sv/pcf_cordic.sv -----
`timescale 1ns / 1ps
module pcf_cordic (
   input  logic                                      clock,
   input  pcf_pkg::cordic_ctl_type                   ctl,
   input  logic [4:0]                                step,
   input  logic signed [15:0]                        accel_x,
   input  logic signed [15:0]                        accel_z,
   output logic signed [24:0]                        angle
);

   localparam int unsigned W = pcf_pkg::CordicWidth;

   logic signed [W-1:0] x_ff, x_in, y_ff, y_in;
   logic signed [pcf_pkg::AngleWidth-1:0] z_ff, z_in;
   logic                zero_ff, zero_in;
   logic signed [W-1:0] xs, ys, x0, y0;
   logic signed [pcf_pkg::AngleWidth-1:0] at, negz;

   always_comb begin
      x0 = W'(accel_z) <<< pcf_pkg::VecShift;
      y0 = W'(accel_x) <<< pcf_pkg::VecShift;
      xs = x_ff >>> step;
      ys = y_ff >>> step;
      at = pcf_pkg::atan_lookup(step);
      x_in = x_ff;
      y_in = y_ff;
      z_in = z_ff;
      zero_in = zero_ff;
      if (ctl.load) begin
         zero_in = (accel_x == '0) && (accel_z == '0);
         if (x0 < 0) begin
            x_in = -x0;
            y_in = -y0;
            z_in = (y0 >= 0) ? pcf_pkg::Ang180 : -pcf_pkg::Ang180;
         end else begin
            x_in = x0;
            y_in = y0;
            z_in = '0;
         end
      end else if (ctl.rotate) begin
         if (y_ff >= 0) begin
            x_in = x_ff + ys;
            y_in = y_ff - xs;
            z_in = z_ff + at;
         end else begin
            x_in = x_ff - ys;
            y_in = y_ff + xs;
            z_in = z_ff - at;
         end
      end
   end

   always_ff @(posedge clock) begin
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
      zero_ff <= zero_in;
   end

   always_comb begin
      negz = -z_ff;
      if (zero_ff) begin
         angle = '0;
      end else if (negz > pcf_pkg::Ang180) begin
         angle = 25'(pcf_pkg::Ang180);
      end else if (negz < -pcf_pkg::Ang180) begin
         angle = 25'(-pcf_pkg::Ang180);
      end else begin
         angle = negz[24:0];
      end
   end

endmodule

// ----- sv/pcf_ctrl.sv -----
`timescale 1ns / 1ps
module pcf_ctrl #(
   parameter int unsigned CORDIC_STEPS = pcf_pkg::CordicStepsDefault
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic                      out_taken,
   output pcf_pkg::state_type        state,
   output pcf_pkg::cordic_ctl_type   ctl,
   output logic [4:0]                step
);

   pcf_pkg::state_type state_ff, state_in;
   logic [4:0] step_ff, step_in;
   logic last;

   assign last  = (step_ff == 5'(CORDIC_STEPS - 1));
   assign state = state_ff;
   assign step  = step_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         pcf_pkg::ST_IDLE:     if (start) state_in = pcf_pkg::ST_ROTATE;
         pcf_pkg::ST_ROTATE:   if (last) state_in = pcf_pkg::ST_MUL_GAIN;
         pcf_pkg::ST_MUL_GAIN: state_in = pcf_pkg::ST_MUL_ACC;
         pcf_pkg::ST_MUL_ACC:  state_in = pcf_pkg::ST_MUL_GYR;
         pcf_pkg::ST_MUL_GYR:  state_in = pcf_pkg::ST_SUM;
         pcf_pkg::ST_SUM:      state_in = pcf_pkg::ST_DONE;
         pcf_pkg::ST_DONE:     if (out_taken) state_in = pcf_pkg::ST_IDLE;
         default:              state_in = pcf_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      ctl = '0;
      step_in = '0;
      case (state_ff)
         pcf_pkg::ST_IDLE:   ctl.load = start;
         pcf_pkg::ST_ROTATE: begin
            ctl.rotate = 1'b1;
            step_in = last ? 5'd0 : step_ff + 5'd1;
         end
         default: ctl = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pcf_pkg::ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

endmodule

// ----- sv/pitch_complementary_filter_core.sv -----
`timescale 1ns / 1ps
// After an input transaction is accepted, the sequencer runs the CORDIC_STEPS (20 by default)
// rotation steps of the shared CORDIC rotator in ST_ROTATE, one micro-rotation per cycle,
// then passes through ST_MUL_GAIN, ST_MUL_ACC, ST_MUL_GYR and ST_SUM and offers the result
// in ST_DONE. No new input transaction is taken until the result has been taken.
// Reset (synchronous, active high) clears the sequencer and the fused angle and
// restores the register defaults.
module pitch_complementary_filter_core #(
   parameter int unsigned CORDIC_STEPS = pcf_pkg::CordicStepsDefault
) (
   input  logic        clock,
   input  logic        reset,
   // Input stream: tdata = accel_x[15:0], accel_z[31:16], gyro_y[47:32].
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,
   // Result stream: tdata = accel_angle[24:0], gyro_angle[56:25], fused_angle[88:57],
   // zero fill to 96 bits.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [95:0] rsp_tdata,
   // Configuration port.
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   // Configuration registers. Writes land in the access phase of a transaction.
   logic signed [15:0] offset_ff;
   logic [15:0]        gain_ff;
   logic [16:0]        alpha_ff;
   logic               wr;
   logic [1:0]         reg_idx;

   assign csr_pready = 1'b1;
   assign wr         = csr_psel && csr_penable && csr_pwrite;
   assign reg_idx    = csr_paddr[3:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff <= pcf_pkg::GyroOffsetReset;
         gain_ff   <= pcf_pkg::GyroGainReset;
         alpha_ff  <= pcf_pkg::BlendAlphaReset;
      end else if (wr && csr_paddr[1:0] == 2'b00) begin
         case (reg_idx)
            pcf_pkg::RegGyroOffset: offset_ff <= csr_pwdata[15:0];
            pcf_pkg::RegGyroGain:   gain_ff   <= csr_pwdata[15:0];
            pcf_pkg::RegBlendAlpha: alpha_ff  <= csr_pwdata[16:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         pcf_pkg::RegGyroOffset: csr_prdata = {16'd0, offset_ff};
         pcf_pkg::RegGyroGain:   csr_prdata = {16'd0, gain_ff};
         pcf_pkg::RegBlendAlpha: csr_prdata = {15'd0, alpha_ff};
         default:                csr_prdata = '0;
      endcase
   end

   // Sequencer and shared CORDIC rotator.
   pcf_pkg::state_type      state;
   pcf_pkg::cordic_ctl_type ctl;
   logic [4:0]              step;
   logic                    start;
   logic signed [24:0]      acc_angle;

   assign req_tready = (state == pcf_pkg::ST_IDLE);
   assign start      = req_tvalid && req_tready;
   assign rsp_tvalid = (state == pcf_pkg::ST_DONE);

   pcf_ctrl #(.CORDIC_STEPS(CORDIC_STEPS)) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .out_taken (rsp_tvalid && rsp_tready),
      .state     (state),
      .ctl       (ctl),
      .step      (step)
   );

   pcf_cordic u_cordic (
      .clock   (clock),
      .ctl     (ctl),
      .step    (step),
      .accel_x (req_tdata[15:0]),
      .accel_z (req_tdata[31:16]),
      .angle   (acc_angle)
   );

   // The gyro correction is captured with the input transaction, saturated to 16 bits.
   logic signed [16:0] gdiff;
   logic signed [15:0] g_ff;
   assign gdiff = 17'(signed'(req_tdata[47:32])) - 17'(offset_ff);

   always_ff @(posedge clock) begin
      if (start) begin
         if (gdiff > 17'sd32767)       g_ff <= 16'sh7FFF;
         else if (gdiff < -17'sd32768) g_ff <= 16'sh8000;
         else                          g_ff <= gdiff[15:0];
      end
   end

   // One shared 34 x 33 signed multiplier, used once in each of three states.
   logic [16:0]        alpha_sat;
   logic signed [33:0] mul_a;
   logic signed [32:0] mul_b;
   logic signed [66:0] prod;
   logic signed [66:0] prod_ff;
   logic signed [66:0] acc_term_ff;
   logic signed [33:0] gsum;
   logic signed [31:0] gyr_ff, gyr_in;
   logic signed [31:0] filt_ff;
   logic signed [31:0] fused_ff;
   logic signed [66:0] blend, shifted;

   assign alpha_sat = (alpha_ff > pcf_pkg::AlphaOne) ? pcf_pkg::AlphaOne : alpha_ff;

   always_comb begin
      mul_a = 34'(g_ff);
      mul_b = 33'(gain_ff);
      case (state)
         pcf_pkg::ST_MUL_ACC: begin
            mul_a = 34'(acc_angle);
            mul_b = 33'(alpha_sat);
         end
         pcf_pkg::ST_MUL_GYR: begin
            mul_a = 34'(gyr_ff);
            mul_b = 33'(pcf_pkg::AlphaOne - alpha_sat);
         end
         default: ;
      endcase
      prod = 67'(mul_a) * 67'(mul_b);
   end

   always_comb begin
      gsum = 34'(filt_ff) + prod_ff[33:0];
      if (gsum > 34'sh07FFFFFFF)       gyr_in = 32'sh7FFFFFFF;
      else if (gsum < -34'sh080000000) gyr_in = 32'sh80000000;
      else                             gyr_in = gsum[31:0];
      blend   = acc_term_ff + prod_ff;
      shifted = blend >>> 16;
   end

   always_ff @(posedge clock) begin
      if (state == pcf_pkg::ST_MUL_GAIN || state == pcf_pkg::ST_MUL_ACC ||
          state == pcf_pkg::ST_MUL_GYR) begin
         prod_ff <= prod;
      end
      if (state == pcf_pkg::ST_MUL_ACC) gyr_ff <= gyr_in;
      if (state == pcf_pkg::ST_MUL_GYR) acc_term_ff <= prod_ff;
   end

   // Fused angle state; reset clears it.
   always_ff @(posedge clock) begin
      if (reset) begin
         filt_ff <= '0;
      end else if (state == pcf_pkg::ST_SUM) begin
         if (shifted > 67'sh07FFFFFFF)       filt_ff <= 32'sh7FFFFFFF;
         else if (shifted < -67'sh080000000) filt_ff <= 32'sh80000000;
         else                                filt_ff <= shifted[31:0];
      end
   end

   assign fused_ff  = filt_ff;
   assign rsp_tdata = {7'd0, fused_ff, gyr_ff, acc_angle};

   // The block holds off new input transactions while a result is pending.
   a_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready) else $error("ready while result pending");
   // A result stays offered until it is taken.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result dropped");
   // An accepted transaction starts the rotator.
   a_start: assert property (@(posedge clock) disable iff (reset)
      start |=> state == pcf_pkg::ST_ROTATE) else $error("rotator not started");

endmodule
